@@ rtl/core/afs_pkg.sv @@
`timescale 1ns / 1ps

package afs_pkg;

  // Widths of the frame and loop paths
  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned LOOP_BITS  = 16;
  localparam int unsigned LIMIT_BITS = LOOP_BITS + 1;

  // APB port geometry: seven 32-bit registers at byte offsets 4*i
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 5;
  localparam int unsigned REG_IDX_LO = 2;

  // Command codes
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_PLAY  = 3'd1;
  localparam logic [2:0] FUNC_PAUSE = 3'd2;
  localparam logic [2:0] FUNC_STOP  = 3'd3;
  localparam logic [2:0] FUNC_SEEK  = 3'd4;

  // Playback state codes
  localparam logic [1:0] RUN_STOPPED  = 2'd0;
  localparam logic [1:0] RUN_PLAYING  = 2'd1;
  localparam logic [1:0] RUN_PAUSED   = 2'd2;
  localparam logic [1:0] RUN_STOPPING = 2'd3;

  // Stop modes
  localparam logic [1:0] STOP_CURRENT = 2'd0;
  localparam logic [1:0] STOP_FIRST   = 2'd1;
  localparam logic [1:0] STOP_LAST    = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_RANGE_START = 3'd0;
  localparam logic [2:0] REG_RANGE_END   = 3'd1;
  localparam logic [2:0] REG_TOTAL       = 3'd2;
  localparam logic [2:0] REG_LOOP_LIMIT  = 3'd3;
  localparam logic [2:0] REG_REVERSE     = 3'd4;
  localparam logic [2:0] REG_STOP_MODE   = 3'd5;
  localparam logic [2:0] REG_NOTIFY      = 3'd6;

  typedef struct packed {
    logic [2:0]            func;
    logic [FRAME_BITS-1:0] seek_frame;
    logic [FRAME_BITS-1:0] skipped_frames;
    logic                  render_ok;
  } cmd_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_to_render;
    logic [1:0]            run_state;
    logic                  finished_event;
    logic                  force_render;
    logic                  keep_animating;
    logic                  seek_rejected;
  } res_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] first;
    logic [FRAME_BITS-1:0] last;
  } range_t;

  // Settings that the sequencer reads every item
  typedef struct packed {
    range_t                       eff;
    logic signed [LIMIT_BITS-1:0] loop_limit;
    logic                         reverse_mode;
    logic [1:0]                   stop_mode;
    logic                         notify_each_render;
  } cfg_t;

  // Side effects of a register write on the sequencer state
  typedef struct packed {
    logic   range_chg;
    range_t new_eff;
    logic   loop_clr;
  } cfg_upd_t;

  // Clamp both ends to total-1 (zero total counts as one), then order them
  function automatic range_t eff_range(input logic [FRAME_BITS-1:0] rs,
                                       input logic [FRAME_BITS-1:0] re,
                                       input logic [FRAME_BITS-1:0] tot);
    logic [FRAME_BITS-1:0] top;
    logic [FRAME_BITS-1:0] a;
    logic [FRAME_BITS-1:0] b;
    range_t                r;
    top = (tot == '0) ? '0 : tot - FRAME_BITS'(1);
    a   = (rs < top) ? rs : top;
    b   = (re < top) ? re : top;
    if (a > b) begin
      r.first = b;
      r.last  = a;
    end else begin
      r.first = a;
      r.last  = b;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/afs_if.sv @@
`timescale 1ns / 1ps

interface afs_cmd_if;
  import afs_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface afs_res_if;
  import afs_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/afs_cfg_regs.sv @@
`timescale 1ns / 1ps

module afs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [afs_pkg::APB_AW-1:0]    paddr,
  input  logic [afs_pkg::APB_DW-1:0]    pwdata,
  output logic [afs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output afs_pkg::cfg_t                 cfg_o,
  output afs_pkg::cfg_upd_t             upd_o
);
  import afs_pkg::*;

  logic [FRAME_BITS-1:0] range_start_q, range_start_d;
  logic [FRAME_BITS-1:0] range_end_q, range_end_d;
  logic [FRAME_BITS-1:0] total_q, total_d;
  logic [LIMIT_BITS-1:0] limit_q, limit_d;
  logic                  reverse_q, reverse_d;
  logic [1:0]            stop_mode_q, stop_mode_d;
  logic                  notify_q, notify_d;

  logic       wr;
  logic [2:0] idx;
  range_t     cur_eff;
  range_t     new_eff;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[REG_IDX_LO+2:REG_IDX_LO];

  always_comb begin
    range_start_d = range_start_q;
    range_end_d   = range_end_q;
    total_d       = total_q;
    limit_d       = limit_q;
    reverse_d     = reverse_q;
    stop_mode_d   = stop_mode_q;
    notify_d      = notify_q;
    if (wr) begin
      unique case (idx)
        REG_RANGE_START: range_start_d = pwdata[FRAME_BITS-1:0];
        REG_RANGE_END:   range_end_d   = pwdata[FRAME_BITS-1:0];
        REG_TOTAL:       total_d       = pwdata[FRAME_BITS-1:0];
        REG_LOOP_LIMIT:  limit_d       = pwdata[LIMIT_BITS-1:0];
        REG_REVERSE:     reverse_d     = pwdata[0];
        REG_STOP_MODE:   stop_mode_d   = pwdata[1:0];
        REG_NOTIFY:      notify_d      = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= '0;
      range_end_q   <= '0;
      total_q       <= FRAME_BITS'(1);
      limit_q       <= '1;
      reverse_q     <= 1'b0;
      stop_mode_q   <= STOP_CURRENT;
      notify_q      <= 1'b0;
    end else begin
      range_start_q <= range_start_d;
      range_end_q   <= range_end_d;
      total_q       <= total_d;
      limit_q       <= limit_d;
      reverse_q     <= reverse_d;
      stop_mode_q   <= stop_mode_d;
      notify_q      <= notify_d;
    end
  end

  assign cur_eff = eff_range(range_start_q, range_end_q, total_q);
  assign new_eff = eff_range(range_start_d, range_end_d, total_d);

  assign cfg_o.eff                = cur_eff;
  assign cfg_o.loop_limit         = limit_q;
  assign cfg_o.reverse_mode       = reverse_q;
  assign cfg_o.stop_mode          = stop_mode_q;
  assign cfg_o.notify_each_render = notify_q;

  assign upd_o.range_chg = wr && (new_eff != cur_eff);
  assign upd_o.new_eff   = new_eff;
  assign upd_o.loop_clr  = wr && (limit_d != limit_q);

  always_comb begin
    unique case (idx)
      REG_RANGE_START: prdata = {{(APB_DW-FRAME_BITS){1'b0}}, range_start_q};
      REG_RANGE_END:   prdata = {{(APB_DW-FRAME_BITS){1'b0}}, range_end_q};
      REG_TOTAL:       prdata = {{(APB_DW-FRAME_BITS){1'b0}}, total_q};
      REG_LOOP_LIMIT:  prdata = {{(APB_DW-LIMIT_BITS){limit_q[LIMIT_BITS-1]}}, limit_q};
      REG_REVERSE:     prdata = {{(APB_DW-1){1'b0}}, reverse_q};
      REG_STOP_MODE:   prdata = {{(APB_DW-2){1'b0}}, stop_mode_q};
      REG_NOTIFY:      prdata = {{(APB_DW-1){1'b0}}, notify_q};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/afs_seq_state.sv @@
`timescale 1ns / 1ps

module afs_seq_state (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  afs_pkg::cmd_t     cmd_i,
  input  afs_pkg::cfg_t     cfg_i,
  input  afs_pkg::cfg_upd_t upd_i,
  output afs_pkg::res_t     res_o
);
  import afs_pkg::*;

  logic [1:0]            rs_q, rs_d;
  logic [FRAME_BITS-1:0] cf_q, cf_d;
  logic [LOOP_BITS-1:0]  lc_q, lc_d;
  logic                  fwd_q, fwd_d;
  logic                  adv_q, adv_d;
  logic                  fpend_q, fpend_d;
  logic                  fnw_q, fnw_d;

  logic [FRAME_BITS-1:0] s;
  logic [FRAME_BITS-1:0] e;
  logic [FRAME_BITS:0]   c_fwd;
  logic [FRAME_BITS-1:0] c_bwd;
  logic [FRAME_BITS:0]   c_raw;
  logic [FRAME_BITS:0]   c_lo;
  logic [FRAME_BITS-1:0] adv_frame;
  logic [LOOP_BITS-1:0]  lc_inc;
  logic                  limit_neg;
  logic                  again;
  logic                  ok;

  logic [FRAME_BITS-1:0] frame;
  logic                  stopped;
  logic                  finished;
  logic                  fin_ev;
  logic                  force_ev;
  logic                  rejected;

  assign s  = cfg_i.eff.first;
  assign e  = cfg_i.eff.last;
  assign ok = cmd_i.render_ok;

  // Step size is the dropped count plus one; backward stops at zero
  assign c_fwd = {1'b0, cf_q} + {1'b0, cmd_i.skipped_frames} + (FRAME_BITS+1)'(1);
  assign c_bwd = (cf_q > cmd_i.skipped_frames) ?
                 cf_q - cmd_i.skipped_frames - FRAME_BITS'(1) : '0;
  assign c_raw = fwd_q ? c_fwd : {1'b0, c_bwd};
  assign c_lo  = (c_raw < {1'b0, s}) ? {1'b0, s} : c_raw;
  assign adv_frame = (c_lo > {1'b0, e}) ? e : c_lo[FRAME_BITS-1:0];

  // Loop count saturates; a negative limit loops forever without counting
  assign limit_neg = cfg_i.loop_limit[LIMIT_BITS-1];
  assign lc_inc    = (lc_q == '1) ? lc_q : lc_q + LOOP_BITS'(1);
  assign again     = limit_neg || ({1'b0, lc_inc} < cfg_i.loop_limit);

  always_comb begin
    rs_d     = rs_q;
    cf_d     = cf_q;
    lc_d     = lc_q;
    fwd_d    = fwd_q;
    adv_d    = adv_q;
    fpend_d  = fpend_q;
    fnw_d    = fnw_q;
    frame    = cf_q;
    stopped  = 1'b0;
    finished = 1'b0;
    fin_ev   = 1'b0;
    force_ev = 1'b0;
    rejected = 1'b0;
    if (step_i) begin
      unique case (cmd_i.func)
        FUNC_TICK: begin
          if (rs_q == RUN_PLAYING && adv_q) begin
            cf_d = adv_frame;
          end
          frame = cf_d;
          adv_d = 1'b1;
          if (rs_q == RUN_STOPPING) begin
            if (cfg_i.stop_mode == STOP_FIRST) begin
              cf_d = s;
            end else if (cfg_i.stop_mode == STOP_LAST) begin
              cf_d = cfg_i.reverse_mode ? s : e;
            end
            frame   = cf_d;
            stopped = 1'b1;
          end else if (rs_q == RUN_PLAYING) begin
            if (frame >= e) begin
              if (cfg_i.reverse_mode) begin
                fwd_d = 1'b0;
              end else begin
                if (!limit_neg) begin
                  lc_d = lc_inc;
                end
                if (again) begin
                  cf_d  = s;
                  adv_d = 1'b0;
                end else begin
                  finished = 1'b1;
                end
              end
            end else if (frame == s && !fwd_q) begin
              if (!limit_neg) begin
                lc_d = lc_inc;
              end
              if (again) begin
                fwd_d = 1'b1;
              end else begin
                finished = 1'b1;
              end
            end
            if (finished) begin
              if (cfg_i.stop_mode == STOP_CURRENT) begin
                stopped = 1'b1;
              end else begin
                rs_d = RUN_STOPPING;
              end
            end
          end
          if (!ok) begin
            adv_d = 1'b0;
          end
          if (stopped && ok) begin
            rs_d    = RUN_STOPPED;
            fwd_d   = 1'b1;
            lc_d    = '0;
            fpend_d = 1'b1;
            fin_ev  = fnw_q;
          end
          if (ok && (cfg_i.notify_each_render || fpend_d)) begin
            force_ev = 1'b1;
            fpend_d  = 1'b0;
          end
        end
        FUNC_PLAY: begin
          if (rs_q != RUN_PLAYING) begin
            fnw_d = 1'b1;
            adv_d = 1'b0;
            rs_d  = RUN_PLAYING;
          end
          frame = cf_d;
        end
        FUNC_PAUSE: begin
          if (rs_q == RUN_PLAYING) begin
            rs_d    = RUN_PAUSED;
            fpend_d = 1'b1;
          end
          frame = cf_d;
        end
        FUNC_STOP: begin
          if (rs_q != RUN_STOPPING) begin
            fnw_d = 1'b0;
            rs_d  = RUN_STOPPING;
          end
          frame = cf_d;
        end
        FUNC_SEEK: begin
          if (cmd_i.seek_frame != cf_q) begin
            if (cmd_i.seek_frame >= s && cmd_i.seek_frame <= e) begin
              cf_d  = cmd_i.seek_frame;
              adv_d = 1'b0;
              if (rs_q != RUN_PLAYING) begin
                fpend_d = 1'b1;
              end
            end else begin
              rejected = 1'b1;
            end
          end
          frame = cf_d;
        end
        default: frame = cf_d;
      endcase
    end else begin
      // Register writes must land only while no item is in flight: a user rule, not enforced here
      if (upd_i.range_chg) begin
        if (cf_q < upd_i.new_eff.first) begin
          cf_d = upd_i.new_eff.first;
          if (rs_q != RUN_PLAYING) begin
            fpend_d = 1'b1;
          end
        end else if (cf_q > upd_i.new_eff.last) begin
          cf_d = upd_i.new_eff.last;
          if (rs_q != RUN_PLAYING) begin
            fpend_d = 1'b1;
          end
        end
      end
      if (upd_i.loop_clr) begin
        lc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q    <= RUN_STOPPED;
      cf_q    <= '0;
      lc_q    <= '0;
      fwd_q   <= 1'b1;
      adv_q   <= 1'b0;
      fpend_q <= 1'b0;
      fnw_q   <= 1'b1;
    end else begin
      rs_q    <= rs_d;
      cf_q    <= cf_d;
      lc_q    <= lc_d;
      fwd_q   <= fwd_d;
      adv_q   <= adv_d;
      fpend_q <= fpend_d;
      fnw_q   <= fnw_d;
    end
  end

  assign res_o.frame_to_render = frame;
  assign res_o.run_state       = rs_d;
  assign res_o.finished_event  = fin_ev;
  assign res_o.force_render    = force_ev;
  assign res_o.keep_animating  = (rs_d == RUN_PLAYING) || (rs_d == RUN_STOPPING);
  assign res_o.seek_rejected   = rejected;

endmodule

@@ rtl/core/animation_frame_sequencer_core.sv @@
`timescale 1ns / 1ps

// Frame playback sequencer.
// cmd_i carries one command beat (tick, play, pause, stop, seek); every
// command beat yields exactly one result beat on res_o, in order.
// Settings arrive over the APB port (pready tied high, one register per
// 32-bit word); write them only while no command is in flight.
// Path: command beat -> input register -> one pass of sequencing logic,
// which updates the playback state -> result register.
// A taken beat waits in the input register until the result register is
// free or draining, then is loaded there and offered on res_o from then on.
// Throughput: one beat per cycle while res_o is not held off; the state loop
// (frame, direction, loop count, run state) closes via the sequencing logic.
// Stall: while res_o is held off, the result register holds its beat and
// the input register still takes one more command; then cmd_i.ready drops.
// Reset: stopped, frame 0, loop count 0, forward, registers at defaults,
// both pipeline registers empty.
module animation_frame_sequencer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [afs_pkg::APB_AW-1:0] paddr,
  input  logic [afs_pkg::APB_DW-1:0] pwdata,
  output logic [afs_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  afs_cmd_if.sink                    cmd_i,
  afs_res_if.source                  res_o
);
  import afs_pkg::*;

  cfg_t     cfg;
  cfg_upd_t upd;

  logic in_valid_q, in_valid_d;
  cmd_t in_data_q;
  logic out_valid_q, out_valid_d;
  res_t out_data_q;
  res_t step_res;
  logic fire;

  afs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .upd_o   (upd)
  );

  // Process the held command whenever the result register is free or draining
  assign fire        = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || fire;

  afs_seq_state u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .cmd_i  (in_data_q),
    .cfg_i  (cfg),
    .upd_i  (upd),
    .res_o  (step_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (cmd_i.valid && cmd_i.ready) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_data_q <= cmd_i.data;
    end
    if (fire) begin
      out_data_q <= step_res;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

endmodule

@@ tb/animation_frame_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

// Playback sequencer testbench: directed script, then constrained-by-hand
// random traffic under three idle profiles. Every result beat is checked
// field by field against an in-bench playback model or a typed result.
module animation_frame_sequencer_core_tb;
  import afs_pkg::*;

  localparam int RUN_LIMIT  = 200_000;
  localparam int HOLD_LONG  = 60;
  localparam int PHASE_LEN  = 108;

  // Codes the package leaves unnamed
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [1:0] STOP_HOLD     = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  afs_cmd_if cmd_bus ();
  afs_res_if res_bus ();

  animation_frame_sequencer_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd_i   (cmd_bus),
    .res_o   (res_bus)
  );

  // One line of the directed script: either a register write or a command
  // beat, the latter optionally with a hand-typed result.
  typedef struct {
    bit         is_reg;
    logic [2:0] reg_idx;
    int         reg_val;
    cmd_t       cmd;
    bit         typed;
    res_t       want;
  } script_row_t;

  script_row_t script_rows[$];

  // Settings as the block should hold them
  logic [15:0] cfg_start;
  logic [15:0] cfg_end;
  logic [15:0] cfg_total;
  int          cfg_loop_limit;
  logic        cfg_reverse;
  logic [1:0]  cfg_stop_mode;
  logic        cfg_notify;

  // Playback state as the block should hold it
  logic [1:0]  play_state;
  int unsigned play_frame;
  int unsigned play_loops;
  bit          play_fwd;
  bit          play_adv;
  bit          play_force;
  bit          play_notice;

  res_t        pending_results[$];
  int          fail_count;
  int          cycle_count;
  int          src_idle_pct;
  int          sink_idle_pct;
  logic        long_hold_req;

  // Side channel that travels with each command beat: a typed result that
  // overrides the model's answer for that beat
  logic        row_typed;
  res_t        row_want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Effective play range: clamp both ends to total-1, zero total counts as
  // one, then order the ends.
  function automatic void eff_bounds(output int unsigned lo, output int unsigned hi);
    int unsigned top;
    int unsigned a;
    int unsigned b;
    top = (cfg_total == 16'd0) ? 0 : cfg_total - 1;
    a = (cfg_start < top) ? cfg_start : top;
    b = (cfg_end < top) ? cfg_end : top;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
  endfunction

  // Count one loop; a negative limit loops forever, the count saturates
  function automatic bit loop_again();
    if (cfg_loop_limit < 0) return 1'b1;
    if (play_loops < 65535) play_loops++;
    return int'(play_loops) < cfg_loop_limit;
  endfunction

  // Mirror a register write into the model; a range change pulls the
  // frame inside and, unless playing, asks for a forced render
  function automatic void apply_reg(input logic [2:0] idx, input int v);
    int unsigned lo0;
    int unsigned hi0;
    int unsigned lo1;
    int unsigned hi1;
    int          lim;
    eff_bounds(lo0, hi0);
    case (idx)
      REG_RANGE_START: cfg_start = v[15:0];
      REG_RANGE_END:   cfg_end   = v[15:0];
      REG_TOTAL:       cfg_total = v[15:0];
      REG_LOOP_LIMIT: begin
        lim = int'($signed(v[16:0]));
        if (lim != cfg_loop_limit) begin
          cfg_loop_limit = lim;
          play_loops = 0;
        end
      end
      REG_REVERSE:     cfg_reverse   = v[0];
      REG_STOP_MODE:   cfg_stop_mode = v[1:0];
      REG_NOTIFY:      cfg_notify    = v[0];
      default: ;
    endcase
    eff_bounds(lo1, hi1);
    if ((lo1 != lo0 || hi1 != hi0) && (play_frame < lo1 || play_frame > hi1)) begin
      play_frame = (play_frame < lo1) ? lo1 : hi1;
      if (play_state != RUN_PLAYING) play_force = 1'b1;
    end
  endfunction

  // Advance the playback model by one command beat, return its result
  function automatic res_t sequence_step(input cmd_t c);
    int unsigned lo;
    int unsigned hi;
    int unsigned frame;
    int unsigned nxt;
    bit          stopped;
    bit          finished;
    bit          ok;
    res_t        r;
    eff_bounds(lo, hi);
    r        = '0;
    ok       = c.render_ok;
    stopped  = 1'b0;
    finished = 1'b0;
    frame    = play_frame;
    case (c.func)
      FUNC_TICK: begin
        // Move only when a previous tick has rendered the current frame
        if (play_state == RUN_PLAYING && play_adv) begin
          nxt = play_frame;
          if (play_fwd) nxt = nxt + c.skipped_frames + 1;
          else nxt = (nxt > c.skipped_frames) ? nxt - c.skipped_frames - 1 : 0;
          if (nxt < lo) nxt = lo;
          if (nxt > hi) nxt = hi;
          play_frame = nxt;
        end
        frame    = play_frame;
        play_adv = 1'b1;
        if (play_state == RUN_STOPPING) begin
          if (cfg_stop_mode == STOP_FIRST) play_frame = lo;
          else if (cfg_stop_mode == STOP_LAST) play_frame = cfg_reverse ? lo : hi;
          frame   = play_frame;
          stopped = 1'b1;
        end else if (play_state == RUN_PLAYING) begin
          if (frame >= hi) begin
            if (cfg_reverse) begin
              play_fwd = 1'b0;
            end else if (loop_again()) begin
              play_frame = lo;
              play_adv   = 1'b0;
            end else begin
              finished = 1'b1;
            end
          end else if (frame == lo && !play_fwd) begin
            if (loop_again()) play_fwd = 1'b1;
            else finished = 1'b1;
          end
          if (finished) begin
            if (cfg_stop_mode == STOP_CURRENT) stopped = 1'b1;
            else play_state = RUN_STOPPING;
          end
        end
        // A failed render keeps the next tick from advancing and holds off a stop
        if (!ok) play_adv = 1'b0;
        if (stopped && ok) begin
          play_state = RUN_STOPPED;
          play_fwd   = 1'b1;
          play_loops = 0;
          play_force = 1'b1;
          r.finished_event = play_notice;
        end
        if (ok && (cfg_notify || play_force)) begin
          r.force_render = 1'b1;
          play_force     = 1'b0;
        end
      end
      FUNC_PLAY: begin
        if (play_state != RUN_PLAYING) begin
          play_notice = 1'b1;
          play_adv    = 1'b0;
          play_state  = RUN_PLAYING;
        end
      end
      FUNC_PAUSE: begin
        if (play_state == RUN_PLAYING) begin
          play_state = RUN_PAUSED;
          play_force = 1'b1;
        end
      end
      FUNC_STOP: begin
        if (play_state != RUN_STOPPING) begin
          play_notice = 1'b0;
          play_state  = RUN_STOPPING;
        end
      end
      FUNC_SEEK: begin
        if (c.seek_frame != play_frame) begin
          if (c.seek_frame >= lo && c.seek_frame <= hi) begin
            play_frame = c.seek_frame;
            play_adv   = 1'b0;
            if (play_state != RUN_PLAYING) play_force = 1'b1;
          end else begin
            r.seek_rejected = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (c.func != FUNC_TICK) frame = play_frame;
    r.frame_to_render = frame[15:0];
    r.run_state       = play_state;
    r.keep_animating  = (play_state == RUN_PLAYING) || (play_state == RUN_STOPPING);
    return r;
  endfunction

  function automatic cmd_t mk_cmd(input logic [2:0] f, input int seek, input int skip,
                                  input bit ok);
    cmd_t c;
    c.func           = f;
    c.seek_frame     = seek[15:0];
    c.skipped_frames = skip[15:0];
    c.render_ok      = ok;
    return c;
  endfunction

  function automatic res_t mk_res(input int frame, input logic [1:0] st, input bit fin,
                                  input bit frc, input bit keep, input bit rej);
    res_t r;
    r.frame_to_render = frame[15:0];
    r.run_state       = st;
    r.finished_event  = fin;
    r.force_render    = frc;
    r.keep_animating  = keep;
    r.seek_rejected   = rej;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [2:0] idx, input int v);
    script_row_t row;
    row         = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = v;
    return row;
  endfunction

  function automatic script_row_t cmd_row(input logic [2:0] f, input int seek, input int skip,
                                          input bit ok);
    script_row_t row;
    row     = '{default: '0};
    row.cmd = mk_cmd(f, seek, skip, ok);
    return row;
  endfunction

  function automatic script_row_t chk_row(input logic [2:0] f, input int seek, input int skip,
                                          input bit ok, input res_t want);
    script_row_t row;
    row       = cmd_row(f, seek, skip, ok);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  // Append one line to the directed script
  function automatic void add_row(input script_row_t row);
    script_rows = {script_rows, row};
  endfunction

  // Random command beat: mostly ticks, seeks aimed into the live range,
  // small skips so that playback reaches the range ends
  function automatic cmd_t random_cmd();
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    int unsigned seek;
    int unsigned skip;
    logic [2:0]  f;
    eff_bounds(lo, hi);
    pick = $urandom_range(99);
    if (pick < 56) f = FUNC_TICK;
    else if (pick < 66) f = FUNC_PLAY;
    else if (pick < 71) f = FUNC_PAUSE;
    else if (pick < 75) f = FUNC_STOP;
    else if (pick < 95) f = FUNC_SEEK;
    else f = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
    pick = $urandom_range(99);
    if (pick < 50) seek = $urandom_range(hi, lo);
    else if (pick < 65) seek = play_frame;
    else seek = $urandom_range(65535);
    pick = $urandom_range(99);
    if (pick < 70) skip = $urandom_range(2);
    else if (pick < 85) skip = $urandom_range(hi - lo);
    else skip = $urandom_range(65535);
    return mk_cmd(f, seek, skip, $urandom_range(99) < 88);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Watch both channels at the clock edge: predict on every accepted command
  // beat, compare every accepted result beat with the oldest prediction
  always @(posedge clk_i) begin : watch
    res_t want;
    res_t got;
    if (rst_ni) begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        want = sequence_step(cmd_bus.data);
        if (row_typed) want = row_want;
        pending_results = {pending_results, want};
      end
      if (res_bus.valid && res_bus.ready) begin
        got = res_bus.data;
        if (pending_results.size() == 0) begin
          $error("result beat with no command outstanding: frame %0d", got.frame_to_render);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("frame_to_render", want.frame_to_render, got.frame_to_render);
          check_field("run_state", want.run_state, got.run_state);
          check_field("finished_event", want.finished_event, got.finished_event);
          check_field("force_render", want.force_render, got.force_render);
          check_field("keep_animating", want.keep_animating, got.keep_animating);
          check_field("seek_rejected", want.seek_rejected, got.seek_rejected);
        end
      end
    end
  end

  // Result sink: random stalls per the active profile; on request, hold off
  // for a long stretch so the block fills up and pushes back on cmd_i
  initial begin : sink
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        res_bus.ready <= 1'b0;
        repeat (HOLD_LONG) @(posedge clk_i);
      end else begin
        res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offer one command beat, idling first per the active profile; hold valid
  // until the beat is taken and leave it high for the next one
  task automatic push_cmd(input cmd_t c, input bit typed = 1'b0, input res_t want = '0);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.data  <= c;
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // APB write: setup phase, access phase, then back to idle
  task automatic write_reg(input logic [2:0] idx, input int v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << REG_IDX_LO;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // New settings for one random phase; the shape picks the extremes
  task automatic configure(input int shape);
    int rs;
    int re;
    int tot;
    int lim;
    case (shape)
      0: begin
        tot = 65535;
        rs  = 0;
        re  = 65535;
        lim = -1;
      end
      1: begin
        tot = $urandom_range(1);
        rs  = 65535;
        re  = 0;
        lim = 0;
      end
      2: begin
        tot = $urandom_range(24, 2);
        rs  = $urandom_range(30);
        re  = $urandom_range(30);
        lim = $urandom_range(4);
      end
      3: begin
        tot = $urandom_range(65535, 1);
        rs  = $urandom_range(65535);
        re  = $urandom_range(65535);
        lim = 65535;
      end
      default: begin
        tot = $urandom_range(12, 2);
        rs  = $urandom_range(12);
        re  = $urandom_range(12);
        lim = int'($urandom_range(4)) - 1;
      end
    endcase
    write_reg(REG_RANGE_START, rs);
    write_reg(REG_RANGE_END, re);
    write_reg(REG_TOTAL, tot);
    write_reg(REG_LOOP_LIMIT, lim);
    write_reg(REG_REVERSE, $urandom_range(1));
    write_reg(REG_STOP_MODE, $urandom_range(3));
    write_reg(REG_NOTIFY, $urandom_range(1));
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.data  <= '0;
    row_typed     <= 1'b0;
    row_want      <= '0;
    long_hold_req <= 1'b0;
    fail_count     = 0;
    cycle_count    = 0;
    src_idle_pct   = 0;
    sink_idle_pct  = 0;

    // Model at reset values
    cfg_start      = '0;
    cfg_end        = '0;
    cfg_total      = 16'd1;
    cfg_loop_limit = -1;
    cfg_reverse    = 1'b0;
    cfg_stop_mode  = STOP_CURRENT;
    cfg_notify     = 1'b0;
    play_state     = RUN_STOPPED;
    play_frame     = 0;
    play_loops     = 0;
    play_fwd       = 1'b1;
    play_adv       = 1'b0;
    play_force     = 1'b0;
    play_notice    = 1'b1;

    // Directed script. Out of reset the range is the single frame 0.
    add_row(chk_row(FUNC_TICK, 0, 0, 1'b1, mk_res(0, RUN_STOPPED, 0, 0, 0, 0)));
    add_row(chk_row(FUNC_SEEK, 65535, 0, 1'b1, mk_res(0, RUN_STOPPED, 0, 0, 0, 1)));
    // Seek to the frame already shown: no change, no reject
    add_row(chk_row(FUNC_SEEK, 0, 0, 1'b1, mk_res(0, RUN_STOPPED, 0, 0, 0, 0)));
    // Spare function codes answer like a command and change nothing
    add_row(chk_row(FUNC_SPARE_LO, 0, 0, 1'b0, mk_res(0, RUN_STOPPED, 0, 0, 0, 0)));
    add_row(chk_row(FUNC_SPARE_HI, 65535, 65535, 1'b1,
                    mk_res(0, RUN_STOPPED, 0, 0, 0, 0)));
    // Zero total behaves as one frame
    add_row(reg_row(REG_TOTAL, 0));
    add_row(reg_row(REG_RANGE_END, 65535));
    add_row(chk_row(FUNC_SEEK, 1, 0, 1'b1, mk_res(0, RUN_STOPPED, 0, 0, 0, 1)));
    // Open the range to 2..9: the frame gets pulled to 2, forced render due
    add_row(reg_row(REG_RANGE_START, 2));
    add_row(reg_row(REG_TOTAL, 10));
    add_row(reg_row(REG_LOOP_LIMIT, 1));
    add_row(reg_row(REG_STOP_MODE, STOP_LAST));
    add_row(reg_row(REG_REVERSE, 0));
    add_row(reg_row(REG_NOTIFY, 0));
    add_row(chk_row(FUNC_TICK, 0, 0, 1'b1, mk_res(2, RUN_STOPPED, 0, 1, 0, 0)));
    add_row(chk_row(FUNC_PLAY, 0, 0, 1'b1, mk_res(2, RUN_PLAYING, 0, 0, 1, 0)));
    add_row(cmd_row(FUNC_TICK, 0, 0, 1'b1));
    // Largest skip clamps to the range end and finishes the single loop
    add_row(cmd_row(FUNC_TICK, 0, 65535, 1'b1));
    add_row(cmd_row(FUNC_TICK, 0, 0, 1'b1));
    add_row(cmd_row(FUNC_SEEK, 5, 0, 1'b1));
    add_row(cmd_row(FUNC_STOP, 0, 0, 1'b1));
    // Failed render while stopping: stays stopping, forced render kept
    add_row(cmd_row(FUNC_TICK, 0, 0, 1'b0));
    add_row(cmd_row(FUNC_TICK, 0, 0, 1'b1));
    // Auto reverse with no loops, unused stop mode, render notify on
    add_row(reg_row(REG_REVERSE, 1));
    add_row(reg_row(REG_STOP_MODE, STOP_HOLD));
    add_row(reg_row(REG_NOTIFY, 1));
    add_row(reg_row(REG_LOOP_LIMIT, 0));
    add_row(cmd_row(FUNC_PLAY, 0, 0, 1'b1));
    add_row(cmd_row(FUNC_TICK, 0, 3, 1'b1));
    add_row(cmd_row(FUNC_TICK, 0, 65535, 1'b1));
    add_row(cmd_row(FUNC_TICK, 0, 0, 1'b1));
    add_row(cmd_row(FUNC_PAUSE, 0, 0, 1'b1));
    add_row(cmd_row(FUNC_TICK, 0, 0, 1'b1));
    add_row(cmd_row(FUNC_PLAY, 0, 0, 1'b1));
    add_row(cmd_row(FUNC_PAUSE, 0, 0, 1'b1));
    add_row(cmd_row(FUNC_STOP, 0, 0, 1'b1));
    add_row(cmd_row(FUNC_TICK, 0, 0, 1'b0));
    add_row(cmd_row(FUNC_TICK, 0, 0, 1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script_rows[i]) begin
      if (script_rows[i].is_reg) begin
        drain_results();
        write_reg(script_rows[i].reg_idx, script_rows[i].reg_val);
      end else begin
        push_cmd(script_rows[i].cmd, script_rows[i].typed, script_rows[i].want);
      end
    end

    // Random traffic: sender-light, receiver-light, then no idling at all
    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct  = (mode == 0) ? 15 : (mode == 1) ? 85 : 0;
      sink_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 0;
      for (int shape = 0; shape < 5; shape++) begin
        drain_results();
        configure(shape);
        for (int n = 0; n < PHASE_LEN; n++) begin
          // Long receiver hold-off while beats keep coming
          if (mode == 2 && shape == 1 && n == 40) long_hold_req <= 1'b1;
          // Sender pause until the pipeline is empty
          if (mode == 2 && shape == 2 && n == 55) drain_results();
          push_cmd(random_cmd());
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
